// ----- hw/rtl/tfi_pkg.sv -----
// Shared types and constants for the tolerant tuple find-or-insert table.
`timescale 1ns / 1ps
`default_nettype none

package tfi_pkg;

  // Fixed field widths
  localparam int VAL_W      = 32;
  localparam int NUM_VALUES = 5;
  localparam int TOL_W      = 31;
  localparam int FU_W       = 3;
  localparam int ID_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_FIELDS_DEF  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELDS_USED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [FU_W-1:0]  FIELDS_USED_RST = 3'd5;
  localparam logic [TOL_W-1:0] TOLERANCE_RST   = 31'd1;

  // Special result ids
  localparam logic [ID_W-1:0] ID_EMPTY = 10'h3FF;
  localparam logic [ID_W-1:0] ID_FULL  = 10'h000;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_RESP
  } tfi_state_t;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic cmp;    // load hit flags from a fresh compare
    logic shift;  // hit flags move one cell toward cell 0
    logic wr;     // store the query in the cell addressed by the fill count
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tfi_cell.sv -----
// One table entry: stored fields, tolerance compare and a shifting hit flag.
`timescale 1ns / 1ps
`default_nettype none

module tfi_cell
  import tfi_pkg::*;
#(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire cell_ctrl_t                          ctrl,
  input  wire logic                                live,     // entry index below fill count
  input  wire logic                                sel,      // entry index equals fill count
  input  wire logic [MAX_FIELDS-1:0][VAL_W-1:0]    query,
  input  wire logic [FU_W-1:0]                     active_n,
  input  wire logic [TOL_W-1:0]                    tol,
  input  wire logic                                hit_in,
  output logic                                     hit_out
);

  logic [MAX_FIELDS-1:0][VAL_W-1:0] entry;
  logic                             hit;
  logic [MAX_FIELDS-1:0]            field_ok;
  logic                             match;

  // Entry storage, written once on insert
  always_ff @(posedge clk) begin
    if (ctrl.wr && sel) begin
      entry <= query;
    end
  end

  // Per-field window check: -tol <= query - entry <= tol
  always_comb begin
    logic signed [VAL_W:0] diff;
    logic signed [VAL_W:0] lim;
    lim = $signed({2'b00, tol});
    for (int j = 0; j < MAX_FIELDS; j++) begin
      diff = $signed({query[j][VAL_W-1], query[j]}) - $signed({entry[j][VAL_W-1], entry[j]});
      field_ok[j] = (FU_W'(j) >= active_n) || ((diff <= lim) && (diff >= -lim));
    end
  end

  assign match = &field_ok;

  // Hit flag: loaded by compare, then handed toward the head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.cmp) begin
      hit <= live && match;
    end else if (ctrl.shift) begin
      hit <= hit_in;
    end
  end

  assign hit_out = hit;

endmodule

`default_nettype wire

// ----- hw/rtl/tolerant_tuple_find_or_insert_core.sv -----
// Usage:
//   Input stream s_*: one tuple per transfer. s_tuser flags whether the item
//   carries values; s_tdata holds value_0..value_4. Output stream m_*: one
//   result per input, type_id in m_tdata, inserted/table_full in m_tuser.
//   Config channel cfg_*: index 0 fields_used, index 1 match_tolerance;
//   always ready, write only while no item is in flight.
//   Entries live in a row of TABLE_DEPTH cells. All cells compare against
//   the held query at once, then the hit flags shift toward cell 0 one
//   position per cycle until the first hit or the end of the filled part.
//   An item with values passes from the input transfer through states CMP
//   and SCAN to RESP, which loads the output register; an item without
//   values goes straight to RESP. The shift walk over the row sets how long
//   SCAN lasts, and one item is worked on at a time: the next transfer is
//   taken only once the result has been loaded into the output register.
//   A finished result waits in the output register while the next item can
//   already be taken; a stall on m_tready holds only that register and the
//   item behind it in the response state.
//   Reset (rst, synchronous) empties the table and restores fields_used=5,
//   match_tolerance=1; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tolerant_tuple_find_or_insert_core
  import tfi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [NUM_VALUES*VAL_W-1:0] s_tdata,  // value_0 .. value_4
  input  wire logic                        s_tuser,  // has_params
  // output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [OUT_DATA_W-1:0]            m_tdata,  // type_id, zero fill
  output logic [OUT_USER_W-1:0]            m_tuser,  // inserted, table_full
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  tfi_state_t state, state_next;

  logic [FU_W-1:0]                  fields_used;
  logic [TOL_W-1:0]                 match_tolerance;
  logic [FU_W-1:0]                  active_n;
  logic [MAX_FIELDS-1:0][VAL_W-1:0] query;
  logic [CNT_W-1:0]                 count;
  logic [CNT_W-1:0]                 pos;
  logic [ID_W-1:0]                  res_id;
  logic                             res_ins;
  logic                             res_full;
  logic [TABLE_DEPTH:0]             hit_chain;
  cell_ctrl_t                       ctrl;
  logic                             in_xfer;
  logic                             out_free;
  logic                             scan_end;
  logic                             scan_miss;
  logic                             room;
  logic                             do_insert;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fields_used     <= FIELDS_USED_RST;
      match_tolerance <= TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIELDS_USED:     fields_used     <= cfg_data[FU_W-1:0];
        CFG_MATCH_TOLERANCE: match_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp field count to 1..MAX_FIELDS
  always_comb begin
    if (fields_used == '0) begin
      active_n = FU_W'(1);
    end else if (fields_used > FU_W'(MAX_FIELDS)) begin
      active_n = FU_W'(MAX_FIELDS);
    end else begin
      active_n = fields_used;
    end
  end

  // Scan status
  assign scan_end  = ({1'b0, pos} + 1'b1) >= {1'b0, count};
  assign scan_miss = !hit_chain[0] && scan_end;
  assign room      = count < CNT_W'(TABLE_DEPTH);
  assign do_insert = (state == ST_SCAN) && scan_miss && room;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = s_tuser ? ST_CMP : ST_RESP;
      end
      ST_CMP:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (hit_chain[0] || scan_end) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready   = 1'b0;
    ctrl.cmp   = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.wr    = do_insert;
    unique case (state)
      ST_IDLE: s_tready   = 1'b1;
      ST_CMP:  ctrl.cmp   = 1'b1;
      ST_SCAN: ctrl.shift = 1'b1;
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int j = 0; j < MAX_FIELDS; j++) begin
        query[j] <= s_tdata[j*VAL_W +: VAL_W];
      end
    end
  end

  // Fill count and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else begin
      if (do_insert) count <= count + 1'b1;
      if (state == ST_CMP) begin
        pos <= '0;
      end else if (state == ST_SCAN) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Result decision
  always_ff @(posedge clk) begin
    if (in_xfer && !s_tuser) begin
      res_id   <= ID_EMPTY;
      res_ins  <= 1'b0;
      res_full <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (hit_chain[0]) begin
        res_id   <= ID_W'({1'b0, pos} + 1'b1);
        res_ins  <= 1'b0;
        res_full <= 1'b0;
      end else if (scan_miss && room) begin
        res_id   <= ID_W'({1'b0, count} + 1'b1);
        res_ins  <= 1'b1;
        res_full <= 1'b0;
      end else if (scan_miss) begin
        res_id   <= ID_FULL;
        res_ins  <= 1'b0;
        res_full <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tdata <= OUT_DATA_W'(res_id);
      m_tuser <= {res_full, res_ins};
    end
  end

  // Row of entry cells; hit flags travel toward cell 0
  assign hit_chain[TABLE_DEPTH] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tfi_cell #(
      .MAX_FIELDS(MAX_FIELDS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .live     (CNT_W'(i) < count),
      .sel      (CNT_W'(i) == count),
      .query    (query),
      .active_n (active_n),
      .tol      (match_tolerance),
      .hit_in   (hit_chain[i+1]),
      .hit_out  (hit_chain[i])
    );
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tfi_checker.sv -----
// Port-level checks for the find-or-insert table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tfi_checker
  import tfi_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [OUT_USER_W-1:0] m_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Insert and full never flagged together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("inserted and table_full both set");

  // Full result carries id zero
  a_full_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[ID_W-1:0] == ID_FULL)
    else $error("full result with nonzero id");

  // Insert result carries a real id
  a_ins_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[ID_W-1:0] != ID_FULL &&
                               m_tdata[ID_W-1:0] != ID_EMPTY)
    else $error("insert result with special id");

  // One item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind tolerant_tuple_find_or_insert_core tfi_checker u_tfi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- dv/tuple_table_checker.sv -----
// Watches the find-or-insert core's streams, predicts every answer and checks it.
`timescale 1ns / 1ps

module tuple_table_checker
  import tfi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [NUM_VALUES*VAL_W-1:0] s_tdata,  // value_0 .. value_4
  input  wire logic                        s_tuser,  // has_params
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [OUT_DATA_W-1:0]       m_tdata,  // type_id, zero fill
  input  wire logic [OUT_USER_W-1:0]       m_tuser,  // inserted, table_full
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  output int                               errors,
  output int                               outstanding,
  output int                               hits,
  output int                               inserts,
  output int                               full_misses,
  output int                               empties
);

  typedef struct packed {
    logic [ID_W-1:0] type_id;
    logic            inserted;
    logic            table_full;
  } answer_t;

  // Shadow copy of the table and its registers
  logic [VAL_W-1:0] entry_vals [TABLE_DEPTH][NUM_VALUES];
  int               entry_total;
  logic [FU_W-1:0]  fu_reg;
  logic [TOL_W-1:0] tol_reg;

  // Answers owed by the core, oldest first
  answer_t answers_due[$];

  // Scan entries in order for the first one within tolerance; append on a miss if the table has room
  function automatic answer_t find_or_append(input logic has,
                                             input logic [NUM_VALUES*VAL_W-1:0] flat);
    answer_t          ans;
    logic [VAL_W-1:0] q [NUM_VALUES];
    int               n;
    int               found;
    logic             ok;
    longint           d;
    ans.type_id    = '0;
    ans.inserted   = 1'b0;
    ans.table_full = 1'b0;
    for (int j = 0; j < NUM_VALUES; j++) q[j] = flat[j*VAL_W +: VAL_W];
    n = (fu_reg == 0) ? 1 : ((fu_reg > MAX_FIELDS) ? MAX_FIELDS : int'(fu_reg));
    found = -1;
    if (!has) begin
      ans.type_id = ID_EMPTY;
      return ans;
    end
    for (int e = 0; e < entry_total && found < 0; e++) begin
      ok = 1'b1;
      for (int j = 0; j < n; j++) begin
        d = longint'($signed(q[j])) - longint'($signed(entry_vals[e][j]));
        if (d < 0) d = -d;
        if (d > longint'({1'b0, tol_reg})) ok = 1'b0;
      end
      if (ok) found = e;
    end
    if (found >= 0) begin
      ans.type_id = ID_W'(found + 1);
    end else if (entry_total < TABLE_DEPTH) begin
      for (int j = 0; j < NUM_VALUES; j++) entry_vals[entry_total][j] = q[j];
      entry_total++;
      ans.type_id  = ID_W'(entry_total);
      ans.inserted = 1'b1;
    end else begin
      ans.type_id    = ID_FULL;
      ans.table_full = 1'b1;
    end
    return ans;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Config writes, result transfers and input transfers in one edge process
  always @(posedge clk) begin : watch
    answer_t want;
    answer_t pred;
    if (rst) begin
      answers_due.delete();
      entry_total = 0;
      fu_reg      = FIELDS_USED_RST;
      tol_reg     = TOLERANCE_RST;
      errors      = 0;
      outstanding = 0;
      hits        = 0;
      inserts     = 0;
      full_misses = 0;
      empties     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIELDS_USED) fu_reg = cfg_data[FU_W-1:0];
        else if (cfg_index == CFG_MATCH_TOLERANCE) tol_reg = cfg_data[TOL_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got id %0h user %0b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = answers_due.pop_front();
          check_field("type_id", int'(want.type_id), int'(m_tdata[ID_W-1:0]));
          check_field("inserted", int'(want.inserted), int'(m_tuser[0]));
          check_field("table_full", int'(want.table_full), int'(m_tuser[1]));
          check_field("tdata fill", 0, int'(m_tdata[OUT_DATA_W-1:ID_W]));
        end
      end
      if (s_tvalid && s_tready) begin
        pred = find_or_append(s_tuser, s_tdata);
        answers_due = {answers_due, pred};
        if (!s_tuser) empties++;
        else if (pred.inserted) inserts++;
        else if (pred.table_full) full_misses++;
        else hits++;
      end
      outstanding = answers_due.size();
    end
  end

endmodule

// ----- dv/tolerant_tuple_find_or_insert_core_tb.sv -----
// Stimulus, idling and verdict for the tolerant tuple find-or-insert core.
`timescale 1ns / 1ps

module tolerant_tuple_find_or_insert_core_tb;
  import tfi_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int FIELDS      = MAX_FIELDS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 92;

  typedef logic [NUM_VALUES-1:0][VAL_W-1:0] tuple_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [NUM_VALUES*VAL_W-1:0] s_tdata;  // value_0 .. value_4
  logic                        s_tuser;  // has_params
  logic                        m_tvalid;
  logic                        m_tready;
  logic [OUT_DATA_W-1:0]       m_tdata;  // type_id, zero fill
  logic [OUT_USER_W-1:0]       m_tuser;  // inserted, table_full
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  int errors, outstanding, hits, inserts, full_misses, empties;
  int tx_idle_pct, rx_stall_pct, quiet_cycles, items_sent, cfg_writes;
  logic [TOL_W-1:0] cur_tol;
  tuple_t history[$];

  // Per-phase settings: every fields_used code, tolerances from zero to max
  int unsigned phase_fu  [RAND_PHASES] = '{5, 3, 1, 7, 0, 2, 4, 6};
  int unsigned phase_tol [RAND_PHASES] = '{1, 1000, 0, 1048576, 32'h7FFFFFFF, 15, 255, 3};
  int          phase_tx  [RAND_PHASES] = '{0, 50, 0, 36, 0, 50, 0, 36};
  int          phase_rx  [RAND_PHASES] = '{0, 0, 50, 36, 0, 0, 50, 36};

  tolerant_tuple_find_or_insert_core #(
    .TABLE_DEPTH(DEPTH),
    .MAX_FIELDS (FIELDS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tuple_table_checker #(
    .TABLE_DEPTH(DEPTH),
    .MAX_FIELDS (FIELDS)
  ) answer_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .outstanding(outstanding),
    .hits       (hits),
    .inserts    (inserts),
    .full_misses(full_misses),
    .empties    (empties)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, QUIET_LIMIT, outstanding);
      $display("** tolerant_tuple_find_or_insert_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, with random sender gaps ahead of it
  task automatic send_item(input logic has, input tuple_t vals);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= has;
    s_tdata  <= vals;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (has) history = {history, vals};
  endtask

  // Drop valid and wait until every owed result has left the core
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  // Both registers, written only with the core idle; junk above the fields_used bits
  task automatic set_config(input logic [FU_W-1:0] fu, input logic [TOL_W-1:0] tol);
    logic [CFG_DATA_W-1:0] fu_word;
    settle();
    fu_word = CFG_DATA_W'($urandom);
    fu_word[FU_W-1:0] = fu;
    write_reg(CFG_FIELDS_USED, fu_word);
    write_reg(CFG_MATCH_TOLERANCE, tol);
    cur_tol = tol;
  endtask

  function automatic tuple_t all_fields(input logic [VAL_W-1:0] v);
    tuple_t t;
    for (int j = 0; j < NUM_VALUES; j++) t[j] = v;
    return t;
  endfunction

  function automatic tuple_t fresh_tuple();
    tuple_t t;
    for (int j = 0; j < NUM_VALUES; j++) t[j] = $urandom;
    return t;
  endfunction

  // Corner values per field: most negative, most positive, zero, minus one, or a random value
  function automatic tuple_t extreme_tuple();
    tuple_t t;
    for (int j = 0; j < NUM_VALUES; j++) begin
      case ($urandom_range(4))
        0: t[j] = 32'h8000_0000;
        1: t[j] = 32'h7FFF_FFFF;
        2: t[j] = 32'h0;
        3: t[j] = 32'hFFFF_FFFF;
        default: t[j] = $urandom;
      endcase
    end
    return t;
  endfunction

  // Copy of an earlier tuple, each field nudged inside, onto or just past the tolerance
  function automatic tuple_t near_copy(input tuple_t base);
    tuple_t t;
    longint off;
    for (int j = 0; j < NUM_VALUES; j++) begin
      case ($urandom_range(5))
        3: off = longint'($urandom_range(cur_tol));
        4: off = longint'(cur_tol);
        5: off = longint'(cur_tol) + 1;
        default: off = 0;
      endcase
      if ($urandom_range(1)) off = -off;
      t[j] = base[j] + off[VAL_W-1:0];
    end
    return t;
  endfunction

  task automatic random_item();
    int     roll;
    tuple_t t;
    roll = $urandom_range(99);
    t    = fresh_tuple();
    if (roll < 8) begin
      send_item(1'b0, t);
    end else if (roll < 45 && history.size() != 0) begin
      send_item(1'b1, near_copy(history[$urandom_range(history.size() - 1)]));
    end else if (roll < 52) begin
      send_item(1'b1, extreme_tuple());
    end else begin
      send_item(1'b1, t);
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FIELDS_USED;
    cfg_data     = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    items_sent   = 0;
    cfg_writes   = 0;
    cur_tol      = TOLERANCE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, empty items, exact and near hits, extremes
    send_item(1'b0, all_fields(32'hFFFF_FFFF));
    send_item(1'b1, all_fields(32'h0));
    send_item(1'b1, all_fields(32'h0));
    send_item(1'b1, {32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1});
    send_item(1'b1, {32'd2, 32'd0, 32'd0, 32'd0, 32'd0});
    send_item(1'b1, all_fields(32'h7FFF_FFFF));
    send_item(1'b1, all_fields(32'h8000_0000));
    send_item(1'b1, all_fields(32'h7FFF_FFFE));
    send_item(1'b0, all_fields(32'h0));

    // fields_used 0 compares one field; zero tolerance
    set_config(3'd0, 31'd0);
    send_item(1'b1, {32'd0, 32'd5, 32'd5, 32'd5, 32'd5});
    send_item(1'b1, {32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
    send_item(1'b1, {32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF});

    // fields_used above the maximum; widest tolerance against end-to-end differences
    set_config(3'd7, 31'h7FFF_FFFF);
    send_item(1'b1, all_fields(32'h7FFF_FFFF));
    send_item(1'b1, {{4{32'h7FFF_FFFF}}, 32'h8000_0000});
    send_item(1'b0, fresh_tuple());

    // Random phases; the table fills part way through and stays full
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(FU_W'(phase_fu[p]), TOL_W'(phase_tol[p]));
      tx_idle_pct  = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) settle();
        random_item();
      end
    end

    settle();
    repeat (16) @(negedge clk);
    $display("Covered %0d items over %0d register writes, fields_used 0..7, tolerance 0..max.",
             items_sent, cfg_writes);
    $display("Answers: %0d hits, %0d inserts, %0d full-table misses, %0d empty items.",
             hits, inserts, full_misses, empties);
    if (errors == 0) begin
      $display("** tolerant_tuple_find_or_insert_core: PASSED **");
    end else begin
      $display("** tolerant_tuple_find_or_insert_core: FAILED **");
    end
    $finish;
  end

endmodule
